>>> hdl/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg
// Shared types, constants and the CORDIC arctangent table of the
// geodetic to ECEF converter.
// ----------------------------------------------------------------------------
package gte_pkg;

   localparam int CordicSteps = 32;

   localparam logic signed [33:0] CordicStart = 34'sd652032874;
   localparam logic signed [33:0] Quarter     = 34'sd1073741824;
   localparam logic signed [33:0] NegQuarter  = -34'sd1073741824;
   localparam logic signed [33:0] Half        = 34'sd2147483648;

   // e2 in Q40, and the same split at bit 20 for the rounded N*e2 product
   localparam logic [32:0] E2Q40 = 33'd7360548640;
   localparam logic [12:0] E2Hi  = 13'd7019;
   localparam logic [19:0] E2Lo  = 20'd593696;

   localparam logic [32:0] SemiMajorMm = 33'd6378137000;

   localparam logic StatusOk       = 1'b0;
   localparam logic StatusLatRange = 1'b1;

   typedef struct packed {
      logic               err;
      logic signed [30:0] h;
      logic signed [31:0] slat;
      logic signed [31:0] clat;
      logic signed [31:0] slon;
      logic signed [31:0] clon;
   } trig_type;

   typedef struct packed {
      trig_type    t;
      logic [33:0] n;
      logic [33:0] ne2;
   } radius_type;

   // arctangent of 2^-i in phase units (2^32 is a full turn)
   function automatic logic [31:0] atan_phase(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/gte_req_if.sv
// ----------------------------------------------------------------------------
// gte_req_if
// Geodetic point channel: valid/ready handshake with latitude, longitude
// and altitude payload.
// ----------------------------------------------------------------------------
interface gte_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] latitude_angle;
   logic signed [31:0] longitude_angle;
   logic signed [30:0] altitude_mm;

   modport source (
      output valid, latitude_angle, longitude_angle, altitude_mm,
      input  ready
   );
   modport sink (
      input  valid, latitude_angle, longitude_angle, altitude_mm,
      output ready
   );
endinterface

>>> hdl/gte_rsp_if.sv
// ----------------------------------------------------------------------------
// gte_rsp_if
// ECEF result channel: valid/ready handshake with X, Y, Z and status.
// ----------------------------------------------------------------------------
interface gte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [33:0] ecef_x_mm;
   logic signed [33:0] ecef_y_mm;
   logic signed [33:0] ecef_z_mm;
   logic               status;

   modport source (
      output valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, status,
      input  ready
   );
   modport sink (
      input  valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, status,
      output ready
   );
endinterface

>>> hdl/gte_trig.sv
// ----------------------------------------------------------------------------
// gte_trig
// Angle preparation and two pipelined 32-step rotation CORDICs giving sine
// and cosine of latitude and longitude in Q30. One iteration per stage.
// ----------------------------------------------------------------------------
module gte_trig import gte_pkg::*; #(
   parameter int ANGLE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [31:0] latitude_angle,
   input  logic signed [31:0] longitude_angle,
   input  logic signed [30:0] altitude_mm,
   output logic               out_valid,
   output trig_type           out_data
);

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               flip;
   } lane_type;

   typedef struct packed {
      logic               err;
      logic signed [30:0] h;
   } side_type;

   localparam int ShL = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
   localparam int ShR = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
   localparam logic signed [63:0] LatLimit = 64'sd1 <<< (ANGLE_BITS - 2);

   // bring to a 32-bit phase and fold into +-quarter turn
   function automatic lane_type start_lane(input logic signed [31:0] a);
      logic signed [63:0] e;
      logic signed [33:0] z;
      lane_type           l;
      e = 64'(a);
      e = (e <<< ShL) >>> ShR;
      z = 34'(signed'(e[31:0]));
      l.x = CordicStart;
      l.y = '0;
      l.flip = 1'b0;
      if (z > Quarter) begin
         z = z - Half;
         l.flip = 1'b1;
      end else if (z < NegQuarter) begin
         z = z + Half;
         l.flip = 1'b1;
      end
      l.z = z;
      return l;
   endfunction

   function automatic lane_type rotate(input lane_type a, input logic [4:0] i);
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] da;
      lane_type           r;
      dx = a.x >>> i;
      dy = a.y >>> i;
      da = 34'(atan_phase(i));
      r = a;
      if (a.z >= 0) begin
         r.x = a.x - dy;
         r.y = a.y + dx;
         r.z = a.z - da;
      end else begin
         r.x = a.x + dy;
         r.y = a.y - dx;
         r.z = a.z + da;
      end
      return r;
   endfunction

   lane_type               lat_ff  [0:CordicSteps];
   lane_type               lon_ff  [0:CordicSteps];
   side_type               side_ff [0:CordicSteps];
   logic [CordicSteps:0]   valid_ff;
   side_type               side_in;

   always_comb begin
      side_in.err = (64'(latitude_angle) < -LatLimit) ||
                    (64'(latitude_angle) > LatLimit);
      side_in.h   = altitude_mm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[CordicSteps-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lat_ff[0]  <= start_lane(latitude_angle);
         lon_ff[0]  <= start_lane(longitude_angle);
         side_ff[0] <= side_in;
         for (int k = 0; k < CordicSteps; k++) begin
            lat_ff[k+1]  <= rotate(lat_ff[k], 5'(k));
            lon_ff[k+1]  <= rotate(lon_ff[k], 5'(k));
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid     = valid_ff[CordicSteps];
   assign out_data.err  = side_ff[CordicSteps].err;
   assign out_data.h    = side_ff[CordicSteps].h;
   assign out_data.slat = 32'(lat_ff[CordicSteps].flip ? -lat_ff[CordicSteps].y
                                                       : lat_ff[CordicSteps].y);
   assign out_data.clat = 32'(lat_ff[CordicSteps].flip ? -lat_ff[CordicSteps].x
                                                       : lat_ff[CordicSteps].x);
   assign out_data.slon = 32'(lon_ff[CordicSteps].flip ? -lon_ff[CordicSteps].y
                                                       : lon_ff[CordicSteps].y);
   assign out_data.clon = 32'(lon_ff[CordicSteps].flip ? -lon_ff[CordicSteps].x
                                                       : lon_ff[CordicSteps].x);

endmodule

>>> hdl/gte_radius.sv
// ----------------------------------------------------------------------------
// gte_radius
// Prime-vertical radius N = a / sqrt(1 - e2 sin^2(lat)) and N*e2: squared
// sine, split e2 product, 32-stage square root, 34-stage restoring divide.
// ----------------------------------------------------------------------------
module gte_radius import gte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  trig_type   in_data,
   output logic       out_valid,
   output radius_type out_data
);

   localparam int SqrtSteps = 32;
   localparam int DivSteps  = 34;
   localparam int Last      = 3 + SqrtSteps + 1 + 1 + DivSteps + 1;

   logic [Last:0] valid_ff;
   trig_type      side_ff [0:Last];

   logic [31:0] s2_ff;
   logic [48:0] plo_ff;
   logic [48:0] phi_ff;
   logic [63:0] sqn_ff [0:SqrtSteps];
   logic [63:0] sqr_ff [0:SqrtSteps];
   logic [31:0] root_ff;
   logic [31:0] drem_ff [0:DivSteps];
   logic [33:0] dnq_ff  [0:DivSteps];
   logic [31:0] dr_ff   [0:DivSteps];
   logic [33:0] n_ff;
   logic [46:0] p1_ff;
   logic [53:0] p2_ff;
   logic [33:0] nout_ff;
   logic [33:0] ne2_ff;

   logic signed [63:0] sq_in;
   logic [64:0]        t_in;
   logic [63:0]        w_in;
   logic [63:0]        dvd_in;
   logic [54:0]        lo_in;
   logic [47:0]        ne2_sum_in;

   always_comb begin
      sq_in      = 64'(in_data.slat) * 64'(in_data.slat);
      t_in       = {phi_ff, 16'd0} + 65'(plo_ff);
      w_in       = (64'd1 << 62) - 64'(t_in >> 8);
      dvd_in     = {SemiMajorMm, 31'd0} + 64'(root_ff >> 1);
      lo_in      = 55'(p2_ff) + 55'h80000;
      ne2_sum_in = 48'(p1_ff) + 48'(lo_in >> 20) + 48'h80000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[Last-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_data;
         for (int k = 0; k < Last; k++) begin
            side_ff[k+1] <= side_ff[k];
         end

         s2_ff  <= sq_in[61:30];
         plo_ff <= 49'(E2Q40) * 49'(s2_ff[15:0]);
         phi_ff <= 49'(E2Q40) * 49'(s2_ff[31:16]);

         sqn_ff[0] <= w_in;
         sqr_ff[0] <= '0;
         for (int k = 0; k < SqrtSteps; k++) begin
            if (sqn_ff[k] >= sqr_ff[k] + (64'd1 << (62 - 2 * k))) begin
               sqn_ff[k+1] <= sqn_ff[k] - (sqr_ff[k] + (64'd1 << (62 - 2 * k)));
               sqr_ff[k+1] <= (sqr_ff[k] >> 1) + (64'd1 << (62 - 2 * k));
            end else begin
               sqn_ff[k+1] <= sqn_ff[k];
               sqr_ff[k+1] <= sqr_ff[k] >> 1;
            end
         end

         // round to nearest
         root_ff <= 32'(sqr_ff[SqrtSteps] + 64'(sqn_ff[SqrtSteps] > sqr_ff[SqrtSteps]));

         // quotient fits 34 bits, so the top 30 dividend bits start the remainder
         drem_ff[0] <= 32'(dvd_in[63:34]);
         dnq_ff[0]  <= dvd_in[33:0];
         dr_ff[0]   <= root_ff;
         for (int k = 0; k < DivSteps; k++) begin
            dr_ff[k+1] <= dr_ff[k];
            if ({drem_ff[k], dnq_ff[k][33]} >= {1'b0, dr_ff[k]}) begin
               drem_ff[k+1] <= 32'({drem_ff[k], dnq_ff[k][33]} - {1'b0, dr_ff[k]});
               dnq_ff[k+1]  <= {dnq_ff[k][32:0], 1'b1};
            end else begin
               drem_ff[k+1] <= {drem_ff[k][30:0], dnq_ff[k][33]};
               dnq_ff[k+1]  <= {dnq_ff[k][32:0], 1'b0};
            end
         end

         n_ff  <= dnq_ff[DivSteps];
         p1_ff <= 47'(dnq_ff[DivSteps]) * 47'(E2Hi);
         p2_ff <= 54'(dnq_ff[DivSteps]) * 54'(E2Lo);

         nout_ff <= n_ff;
         ne2_ff  <= 34'(ne2_sum_in >> 20);
      end
   end

   assign out_valid  = valid_ff[Last];
   assign out_data.t = side_ff[Last];
   assign out_data.n = nout_ff;
   assign out_data.ne2 = ne2_ff;

endmodule

>>> hdl/gte_project.sv
// ----------------------------------------------------------------------------
// gte_project
// Projection onto the axes: (N+h)cos(lat) then cos/sin(lon), and
// (N(1-e2)+h)sin(lat), each product rounded half up to whole mm.
// ----------------------------------------------------------------------------
module gte_project import gte_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  radius_type         in_data,
   output logic               out_valid,
   output logic signed [33:0] ecef_x_mm,
   output logic signed [33:0] ecef_y_mm,
   output logic signed [33:0] ecef_z_mm,
   output logic               status
);

   localparam logic signed [66:0] RoundHalf = 67'sd536870912;

   logic [4:0] valid_ff;

   logic signed [34:0] nh_ff, zr_ff;
   logic signed [31:0] slat0_ff, clat0_ff, slon0_ff, clon0_ff;
   logic               err0_ff;
   logic signed [66:0] pxy_ff, pz_ff;
   logic signed [31:0] slon1_ff, clon1_ff;
   logic               err1_ff;
   logic signed [34:0] xy_ff, z2_ff;
   logic signed [31:0] slon2_ff, clon2_ff;
   logic               err2_ff;
   logic signed [66:0] px_ff, py_ff;
   logic signed [34:0] z3_ff;
   logic               err3_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               status_ff;

   logic signed [34:0] n_in, ne2_in, h_in;
   logic signed [66:0] xy_in, z_in, x_in, y_in;

   always_comb begin
      n_in   = $signed(35'({1'b0, in_data.n}));
      ne2_in = $signed(35'({1'b0, in_data.ne2}));
      h_in   = 35'(in_data.t.h);
      xy_in  = (pxy_ff + RoundHalf) >>> 30;
      z_in   = (pz_ff + RoundHalf) >>> 30;
      x_in   = (px_ff + RoundHalf) >>> 30;
      y_in   = (py_ff + RoundHalf) >>> 30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nh_ff    <= n_in + h_in;
         zr_ff    <= n_in - ne2_in + h_in;
         slat0_ff <= in_data.t.slat;
         clat0_ff <= in_data.t.clat;
         slon0_ff <= in_data.t.slon;
         clon0_ff <= in_data.t.clon;
         err0_ff  <= in_data.t.err;

         pxy_ff   <= 67'(nh_ff) * 67'(clat0_ff);
         pz_ff    <= 67'(zr_ff) * 67'(slat0_ff);
         slon1_ff <= slon0_ff;
         clon1_ff <= clon0_ff;
         err1_ff  <= err0_ff;

         xy_ff    <= 35'(xy_in);
         z2_ff    <= 35'(z_in);
         slon2_ff <= slon1_ff;
         clon2_ff <= clon1_ff;
         err2_ff  <= err1_ff;

         px_ff   <= 67'(xy_ff) * 67'(clon2_ff);
         py_ff   <= 67'(xy_ff) * 67'(slon2_ff);
         z3_ff   <= z2_ff;
         err3_ff <= err2_ff;

         // out-of-range latitude forces zero coordinates
         x_ff      <= err3_ff ? '0 : 34'(x_in);
         y_ff      <= err3_ff ? '0 : 34'(y_in);
         z_ff      <= err3_ff ? '0 : 34'(z3_ff);
         status_ff <= err3_ff ? StatusLatRange : StatusOk;
      end
   end

   assign out_valid = valid_ff[4];
   assign ecef_x_mm = x_ff;
   assign ecef_y_mm = y_ff;
   assign ecef_z_mm = z_ff;
   assign status    = status_ff;

endmodule

>>> hdl/geodetic_to_ecef.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// WGS84 geodetic to Earth-centred Earth-fixed conversion in fixed point.
// ----------------------------------------------------------------------------
// Accepts one geodetic point per clock and returns its ECEF X, Y, Z in mm
// with a status bit (set, with zero coordinates, for a latitude beyond a
// quarter turn). The pipeline is 111 register stages deep: 33 for the
// angle fold and CORDIC sine/cosine (one iteration per stage), 73 for the
// prime-vertical radius (e2 product, one square-root bit and one quotient
// bit per stage), and 5 for the axis products, the last of which is the
// output register. Throughput is one transaction per cycle while each
// result is taken as it arrives. When the result is not taken the whole
// pipeline holds, and req.ready drops until it is.
module geodetic_to_ecef import gte_pkg::*; #(
   parameter int ANGLE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   gte_req_if.sink   req,
   gte_rsp_if.source rsp
);

   logic       adv;
   logic       trig_valid;
   trig_type   trig_data;
   logic       rad_valid;
   radius_type rad_data;
   logic       out_valid;

   assign adv       = !out_valid || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = out_valid;

   gte_trig #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_trig (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (req.valid),
      .latitude_angle  (req.latitude_angle),
      .longitude_angle (req.longitude_angle),
      .altitude_mm     (req.altitude_mm),
      .out_valid       (trig_valid),
      .out_data        (trig_data)
   );

   gte_radius u_radius (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (trig_valid),
      .in_data   (trig_data),
      .out_valid (rad_valid),
      .out_data  (rad_data)
   );

   gte_project u_project (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (rad_valid),
      .in_data   (rad_data),
      .out_valid (out_valid),
      .ecef_x_mm (rsp.ecef_x_mm),
      .ecef_y_mm (rsp.ecef_y_mm),
      .ecef_z_mm (rsp.ecef_z_mm),
      .status    (rsp.status)
   );

endmodule
